FILE: rtl/core/shelf_pkg.sv
`default_nettype none

package shelf_pkg;

  // Fixed field widths
  localparam int unsigned RectW  = 10;
  localparam int unsigned CellW  = 10;
  localparam int unsigned AtlasW = 11;

  // Atlas limits and padding
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned Pad       = 2;

  // Working width of edge sums: cursor + row height + cell, all under 2^12
  localparam int unsigned SumW = AtlasW + 2;

  // Doubling steps that cover any edge reachable in SumW bits
  localparam int unsigned GrowSteps = SumW + 1;

  typedef enum logic {
    OpPlace = 1'b0,
    OpClear = 1'b1
  } op_e;

  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFull = 1'b1;

  typedef struct packed {
    op_e              opcode;
    logic [RectW-1:0] rect_width;
    logic [RectW-1:0] rect_height;
  } req_t;

  typedef struct packed {
    logic [CellW-1:0]  cell_x;
    logic [CellW-1:0]  cell_y;
    logic [AtlasW-1:0] atlas_w;
    logic [AtlasW-1:0] atlas_h;
    logic              grew;
    logic              status;
  } rsp_t;

  // Smallest doubling of cur (powers of two from 1 when cur is zero) that
  // covers edge_v; zero when that size passes limit. Candidates are
  // independent, the first one that covers the edge wins.
  function automatic logic [SumW-1:0] grown_size(input logic [SumW-1:0] cur,
                                                 input logic [SumW-1:0] edge_v,
                                                 input logic [SumW-1:0] limit);
    logic [31:0]     base;
    logic [31:0]     cand;
    logic            found;
    logic [SumW-1:0] res;
    base  = (cur == '0) ? 32'd1 : {{(32-SumW){1'b0}}, cur};
    found = 1'b0;
    res   = '0;
    for (int unsigned k = 0; k < GrowSteps; k++) begin
      cand = base << k;
      if (!found && cand >= {{(32-SumW){1'b0}}, edge_v}) begin
        found = 1'b1;
        res   = (cand <= {{(32-SumW){1'b0}}, limit}) ? cand[SumW-1:0] : '0;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/shelf_atlas_packer_unit.sv
// Shelf packer for a growing texture atlas.
// Input channel (in_valid_i / in_ready_o / in_req_i): one request per item,
// either place a rectangle (padded on every side) or clear the packing
// cursor and row height. Output channel (out_valid_o / out_ready_i /
// out_rsp_o): exactly one response per request, in request order, with the
// cell position, the atlas size after the request, a grew flag and a
// no-space status.
// Path: an accepted request is held in the input register, and its response
// is then registered in the output register, where the receiver takes it.
// Throughput: one request per cycle unless the receiver stalls. The packing
// state is read and updated in the same cycle that a request moves from the
// input register to the output register, so consecutive requests see each
// other's updates.
// Receiver stall: the output register holds its response; the input register
// still takes one more request, then in_ready_o drops until out_ready_i.
// Reset: cursor, row height and atlas size go to zero, both registers empty.
`default_nettype none

module shelf_atlas_packer_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire shelf_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output shelf_pkg::rsp_t     out_rsp_o
);
  import shelf_pkg::*;

  localparam logic [SumW-1:0] PadSum  = SumW'(2 * Pad);
  localparam logic [SumW-1:0] LimitW  = SumW'(MaxWidth);
  localparam logic [SumW-1:0] LimitH  = SumW'(MaxHeight);

  // Request and response registers
  logic  in_valid_q;
  req_t  in_req_q;
  logic  out_valid_q;
  rsp_t  out_rsp_q;
  logic  advance;

  // Packing state
  logic [AtlasW-1:0] cursor_x_q, cursor_y_q, row_height_q, width_q, height_q;
  logic [AtlasW-1:0] cursor_x_d, cursor_y_d, row_height_d, width_d, height_d;

  rsp_t rsp_d;

  // Working values
  logic [SumW-1:0] cw, ch, cx, cy, rh, w, h, nw, nh;
  logic            grew, full;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Placement logic
  always_comb begin
    cw   = SumW'(in_req_q.rect_width) + PadSum;
    ch   = SumW'(in_req_q.rect_height) + PadSum;
    cx   = SumW'(cursor_x_q);
    cy   = SumW'(cursor_y_q);
    rh   = SumW'(row_height_q);
    w    = SumW'(width_q);
    h    = SumW'(height_q);
    grew = 1'b0;
    full = 1'b0;
    nw   = grown_size(w, cx + cw, LimitW);
    nh   = '0;

    // Right edge: grow, or wrap to a new row (no space if the cell is still too wide)
    if (cx + cw > w) begin
      if (nw != '0) begin
        w    = nw;
        grew = 1'b1;
      end else begin
        cy = cy + rh;
        cx = '0;
        rh = '0;
        if (cw > w) full = 1'b1;
      end
    end
    if (rh < ch) rh = ch;

    // Bottom edge: grow or report no space
    if (!full && (cy + ch > h)) begin
      nh = grown_size(h, cy + ch, LimitH);
      if (nh != '0) begin
        h    = nh;
        grew = 1'b1;
      end else begin
        full = 1'b1;
      end
    end

    cursor_x_d   = cursor_x_q;
    cursor_y_d   = cursor_y_q;
    row_height_d = row_height_q;
    width_d      = width_q;
    height_d     = height_q;

    rsp_d.cell_x  = '0;
    rsp_d.cell_y  = '0;
    rsp_d.atlas_w = width_q;
    rsp_d.atlas_h = height_q;
    rsp_d.grew    = 1'b0;
    rsp_d.status  = StatusOk;

    unique case (in_req_q.opcode)
      OpClear: begin
        cursor_x_d   = '0;
        cursor_y_d   = '0;
        row_height_d = '0;
      end
      OpPlace: begin
        if (full) begin
          rsp_d.status = StatusFull;
        end else begin
          rsp_d.cell_x  = cx[CellW-1:0];
          rsp_d.cell_y  = cy[CellW-1:0];
          rsp_d.atlas_w = w[AtlasW-1:0];
          rsp_d.atlas_h = h[AtlasW-1:0];
          rsp_d.grew    = grew;
          cursor_x_d    = AtlasW'(cx + cw);
          cursor_y_d    = cy[AtlasW-1:0];
          row_height_d  = rh[AtlasW-1:0];
          width_d       = w[AtlasW-1:0];
          height_d      = h[AtlasW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      row_height_q <= '0;
      width_q      <= '0;
      height_q     <= '0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q  <= 1'b1;
        cursor_x_q   <= cursor_x_d;
        cursor_y_q   <= cursor_y_d;
        row_height_q <= row_height_d;
        width_q      <= width_d;
        height_q     <= height_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_req_q <= in_req_i;
    if (advance) out_rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none

module testbench;
  import shelf_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned IdlePct    = 33;
  localparam int unsigned RandCount  = 700;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  req_t in_req_i    = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  shelf_atlas_packer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Packer state as seen by the predictor
  logic [AtlasW-1:0] pen_x   = '0;
  logic [AtlasW-1:0] pen_y   = '0;
  logic [AtlasW-1:0] shelf_h = '0;
  logic [AtlasW-1:0] atlas_w = '0;
  logic [AtlasW-1:0] atlas_h = '0;

  rsp_t        cells_due[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  logic        calm       = 1'b0;  // no idling on either side while set

  // Doubling of cur (from 1 when empty) that reaches span; 0 past cap
  function automatic int unsigned doubled_size(input int unsigned cur,
                                               input int unsigned span,
                                               input int unsigned cap);
    int unsigned sz;
    sz = (cur == 0) ? 1 : cur;
    while (sz < span) begin
      sz = sz << 1;
      if (sz > cap) return 0;
    end
    return (sz > cap) ? 0 : sz;
  endfunction

  // Predict one response and advance the packer state
  function automatic rsp_t pack_rect(input req_t r);
    int unsigned cw, ch, cx, cy, rh, w, h, nsz;
    logic        grow, full;
    rsp_t        o;
    cw   = 32'(r.rect_width) + 2 * Pad;
    ch   = 32'(r.rect_height) + 2 * Pad;
    cx   = 32'(pen_x);
    cy   = 32'(pen_y);
    rh   = 32'(shelf_h);
    w    = 32'(atlas_w);
    h    = 32'(atlas_h);
    grow = 1'b0;
    full = 1'b0;
    o    = '0;
    o.atlas_w = atlas_w;
    o.atlas_h = atlas_h;
    o.status  = StatusOk;
    if (r.opcode == OpClear) begin
      pen_x   = '0;
      pen_y   = '0;
      shelf_h = '0;
      return o;
    end
    // right edge: grow the width or wrap onto a new shelf
    if (cx + cw > w) begin
      nsz = doubled_size(w, cx + cw, MaxWidth);
      if (nsz != 0) begin
        w    = nsz;
        grow = 1'b1;
      end else begin
        cy = cy + rh;
        cx = 0;
        rh = 0;
        if (cw > w) full = 1'b1;
      end
    end
    if (rh < ch) rh = ch;
    // bottom edge: grow the height or give up
    if (!full && cy + ch > h) begin
      nsz = doubled_size(h, cy + ch, MaxHeight);
      if (nsz != 0) begin
        h    = nsz;
        grow = 1'b1;
      end else begin
        full = 1'b1;
      end
    end
    if (full) begin
      o.status = StatusFull;
      return o;
    end
    o.cell_x  = CellW'(cx);
    o.cell_y  = CellW'(cy);
    o.atlas_w = AtlasW'(w);
    o.atlas_h = AtlasW'(h);
    o.grew    = grow;
    pen_x   = AtlasW'(cx + cw);
    pen_y   = AtlasW'(cy);
    shelf_h = AtlasW'(rh);
    atlas_w = AtlasW'(w);
    atlas_h = AtlasW'(h);
    return o;
  endfunction

  // Drive one request, idling at random first; predict it once accepted
  task automatic send_req(input req_t r);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    cells_due.push_back(pack_rect(r));
  endtask

  task automatic place_rect(input int unsigned w, input int unsigned h);
    req_t r;
    r.opcode      = OpPlace;
    r.rect_width  = RectW'(w);
    r.rect_height = RectW'(h);
    send_req(r);
  endtask

  task automatic clear_cursor(input int unsigned w, input int unsigned h);
    req_t r;
    r.opcode      = OpClear;
    r.rect_width  = RectW'(w);
    r.rect_height = RectW'(h);
    send_req(r);
  endtask

  // Hold off new requests until every response is back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
  endtask

  // Growth from an empty atlas, repeated doubling on both edges
  task automatic test_growth();
    place_rect(0, 0);
    place_rect(0, 0);
    place_rect(1, 0);
    place_rect(0, 20);
    place_rect(100, 3);
    place_rect(5, 200);
  endtask

  // Cells wider or taller than the limits, and exact-limit cells
  task automatic test_limits();
    place_rect(1023, 0);
    place_rect(0, 1023);
    place_rect(1023, 1023);
    clear_cursor(1023, 1023);
    place_rect(1020, 1020);
    // wraps below the full-size cell, then runs out of height
    place_rect(0, 0);
    place_rect(682, 341);
  endtask

  // Clear keeps the atlas size; shelves wrap by the previous row height
  task automatic test_shelves();
    wait_drained();
    clear_cursor(0, 0);
    place_rect(300, 40);
    place_rect(300, 10);
    place_rect(300, 60);
    place_rect(300, 5);
    place_rect(300, 5);
    place_rect(1019, 1);
    clear_cursor(341, 682);
    place_rect(0, 0);
  endtask

  // Mostly small rectangles so shelves fill up, with rare clears
  task automatic test_random();
    req_t        r;
    int unsigned pick;
    for (int unsigned i = 0; i < RandCount; i++) begin
      calm = (i >= 250 && i < 400);
      if (i % 150 == 149) wait_drained();
      pick          = $urandom_range(0, 99);
      r.opcode      = (pick < 3) ? OpClear : OpPlace;
      if (pick < 75) begin
        r.rect_width  = RectW'($urandom_range(0, 100));
        r.rect_height = RectW'($urandom_range(0, 100));
      end else if (pick < 92) begin
        r.rect_width  = RectW'($urandom_range(0, 400));
        r.rect_height = RectW'($urandom_range(0, 400));
      end else begin
        r.rect_width  = RectW'($urandom_range(0, 1023));
        r.rect_height = RectW'($urandom_range(0, 1023));
      end
      send_req(r);
    end
    calm = 1'b0;
  endtask

  // Receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  task automatic log_miss(input string what, input int unsigned want,
                          input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycles);
  endtask

  // Response checker
  always @(posedge clk_i) begin
    rsp_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_rsp_o;
      if (cells_due.size() == 0) begin
        log_miss("unrequested response", 0, 1);
      end else begin
        want = cells_due.pop_front();
        if (got.cell_x !== want.cell_x)
          log_miss("cell_x", 32'(want.cell_x), 32'(got.cell_x));
        if (got.cell_y !== want.cell_y)
          log_miss("cell_y", 32'(want.cell_y), 32'(got.cell_y));
        if (got.atlas_w !== want.atlas_w)
          log_miss("atlas_w", 32'(want.atlas_w), 32'(got.atlas_w));
        if (got.atlas_h !== want.atlas_h)
          log_miss("atlas_h", 32'(want.atlas_h), 32'(got.atlas_h));
        if (got.grew !== want.grew)
          log_miss("grew", 32'(want.grew), 32'(got.grew));
        if (got.status !== want.status)
          log_miss("status", 32'(want.status), 32'(got.status));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_growth();
    test_limits();
    test_shelves();
    test_random();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && cells_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
